[rtl/sshpt_pkg.sv]
// ----------------------------------------------------------------------------
// sshpt_pkg
// Shared types and constants for the SSH handshake phase tracker.
// ----------------------------------------------------------------------------
package sshpt_pkg;

  // Default number of tracked connections
  localparam int unsigned NUM_CONNS_DEF = 8;

  // Field widths of the stream channels
  localparam int unsigned REQ_W   = 4;
  localparam int unsigned CONN_W  = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 16;

  // Transport phase encoding
  typedef enum logic [PHASE_W-1:0] {
    PH_IDENT   = 3'd0,
    PH_KEXINIT = 3'd1,
    PH_DHINIT  = 3'd2,
    PH_NEWKEYS = 3'd3,
    PH_SERVICE = 3'd4,
    PH_AUTH    = 3'd5,
    PH_OPEN    = 3'd6
  } phase_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_RESET        = 4'd0,
    REQ_IDENT_DONE   = 4'd1,
    REQ_KEXINIT_DONE = 4'd2,
    REQ_KEX_DONE     = 4'd3,
    REQ_NEWKEYS_DONE = 4'd4,
    REQ_SERVICE_DONE = 4'd5,
    REQ_AUTH_DONE    = 4'd6,
    REQ_REKEY_BEGIN  = 4'd7,
    REQ_QUERY        = 4'd8
  } req_t;

  // One connection table entry
  typedef struct packed {
    logic   authed;
    phase_t resume;
    phase_t phase;
  } entry_t;

  localparam entry_t ENTRY_RST = '{authed: 1'b0, resume: PH_SERVICE, phase: PH_IDENT};

  // Controller state
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

[rtl/sshpt_ctrl.sv]
// ----------------------------------------------------------------------------
// sshpt_ctrl
// Controller: accepts one request, then runs the table update once the
// result register is free.
// ----------------------------------------------------------------------------
module sshpt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  sshpt_pkg::dp_status_t status,
  output sshpt_pkg::ctrl_cmd_t  cmd
);
  import sshpt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the previous result is still waiting
        if (!status.out_stall) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sshpt_dp.sv]
// ----------------------------------------------------------------------------
// sshpt_dp
// Datapath: connection table, phase update logic and result register.
// ----------------------------------------------------------------------------
module sshpt_dp #(
  parameter int unsigned NUM_CONNS = sshpt_pkg::NUM_CONNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sshpt_pkg::IN_W-1:0]    in_tdata,
  input  sshpt_pkg::ctrl_cmd_t          cmd,
  output sshpt_pkg::dp_status_t         status,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sshpt_pkg::OUT_W-1:0]   out_tdata
);
  import sshpt_pkg::*;

  localparam int unsigned IDX_W = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;

  // Input fields
  logic [REQ_W-1:0]   in_req;
  logic [CONN_W-1:0]  in_conn;
  logic [PHASE_W-1:0] in_qp;
  logic               in_sent;
  logic               in_active;
  logic [IDX_W-1:0]   in_idx;

  assign in_req    = in_tdata[3:0];
  assign in_conn   = in_tdata[11:4];
  assign in_qp     = in_tdata[14:12];
  assign in_sent   = in_tdata[15];
  assign in_active = in_tdata[16];
  assign in_idx    = in_conn[IDX_W-1:0];

  // Captured request
  logic [REQ_W-1:0]   req_r;
  logic [PHASE_W-1:0] qp_r;
  logic               sent_r;
  logic               active_r;
  logic               ok_r;
  logic [IDX_W-1:0]   idx_r;

  // Connection table and per-entry valid bits
  entry_t             mem [NUM_CONNS];
  logic [NUM_CONNS-1:0] vld_r;
  entry_t             rd_r;
  logic               rd_vld_r;

  // Result register
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic [OUT_W-1:0]   out_data_nxt;

  entry_t cur;
  entry_t upd;
  logic   est;

  // Capture request fields and read the table entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_req;
      qp_r     <= in_qp;
      sent_r   <= in_sent;
      active_r <= in_active;
      idx_r    <= in_idx;
      ok_r     <= (in_conn < CONN_W'(NUM_CONNS));
      rd_r     <= mem[in_idx];
      rd_vld_r <= vld_r[in_idx];
    end
  end

  // Apply the event to the current entry
  always_comb begin
    cur = rd_vld_r ? rd_r : ENTRY_RST;
    upd = cur;
    est = (cur.phase == PH_SERVICE) || (cur.phase == PH_AUTH) || (cur.phase == PH_OPEN);
    unique case (req_r)
      REQ_RESET: begin
        upd.resume = PH_SERVICE;
        upd.phase  = PH_IDENT;
      end
      REQ_IDENT_DONE: begin
        upd.phase = PH_KEXINIT;
      end
      REQ_KEXINIT_DONE: begin
        if (est) begin
          upd.resume = cur.phase;
        end
        upd.phase = PH_DHINIT;
      end
      REQ_KEX_DONE: begin
        upd.phase = PH_NEWKEYS;
      end
      REQ_NEWKEYS_DONE: begin
        upd.phase = cur.resume;
      end
      REQ_SERVICE_DONE: begin
        upd.phase = PH_AUTH;
      end
      REQ_AUTH_DONE: begin
        upd.authed = 1'b1;
        upd.phase  = PH_OPEN;
      end
      REQ_REKEY_BEGIN: begin
        if (est) begin
          upd.resume = cur.phase;
        end
        upd.phase = PH_KEXINIT;
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  // Write back the updated entry
  always_ff @(posedge clk) begin
    if (cmd.exec && ok_r) begin
      mem[idx_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.exec && ok_r) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // Build the result word, all flags dropped for out-of-range connections
  always_comb begin
    out_data_nxt = '0;
    if (ok_r) begin
      out_data_nxt[2:0] = upd.phase;
      out_data_nxt[3]   = upd.authed;
      out_data_nxt[4]   = (upd.phase == PH_IDENT);
      out_data_nxt[5]   = (upd.phase != PH_IDENT) && (upd.phase != PH_DHINIT) &&
                          (upd.phase != PH_NEWKEYS);
      out_data_nxt[6]   = !sent_r;
      out_data_nxt[7]   = (upd.phase == PH_DHINIT);
      out_data_nxt[8]   = (upd.phase == PH_NEWKEYS);
      out_data_nxt[9]   = (upd.phase == PH_SERVICE);
      out_data_nxt[10]  = (upd.phase == PH_AUTH);
      out_data_nxt[11]  = (upd.phase == PH_OPEN) && !active_r;
      out_data_nxt[12]  = (upd.phase == PH_OPEN);
      out_data_nxt[13]  = (PHASE_W'(upd.phase) == qp_r);
    end
  end

  // Result register: load on exec, clear on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign status.out_stall = out_valid_r && !out_tready;
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;

endmodule

[rtl/ssh_handshake_phase_tracker_top.sv]
// ----------------------------------------------------------------------------
// ssh_handshake_phase_tracker_top
// Per-connection SSH transport phase tracker with admissibility flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one request per transfer naming a connection and an
//   event (or a bare query). Output stream (out_*): exactly one result per
//   request, carrying the updated phase and all admissibility flags.
//   Sequence: the input transfer edge reads the connection table entry into a
//   register; once the result register is free, a later edge applies the
//   event, writes the entry back and loads the result register.
//   Requests: a new request is not taken until the previous one has been
//   applied, as the registered table read is followed by the read-modify-write.
//   A finished result sits in the output register while the next request
//   is taken and its entry read; if the receiver stalls, the update of that
//   next request waits until the held result has transferred.
//   Reset: all table valid bits clear, so every connection reads as phase
//   ident, resume phase service, not authenticated. No clearing pass.
//   Connections at or above NUM_CONNS change nothing and return phase ident
//   with all flags low.
// ----------------------------------------------------------------------------
module ssh_handshake_phase_tracker_top #(
  parameter int unsigned NUM_CONNS = sshpt_pkg::NUM_CONNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [3:0] req_type, [11:4] conn, [14:12] query_phase,
  // [15] kexinit_already_sent, [16] exchange_active, [23:17] zero
  input  logic [sshpt_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] phase, [3] authed_flag, [4] admits_ident, [5] admits_kexinit,
  // [6] needs_kexinit_reply, [7] admits_dh_init, [8] admits_newkeys,
  // [9] admits_service, [10] admits_userauth, [11] admits_rekey,
  // [12] is_open, [13] matches_phase, [15:14] zero
  output logic [sshpt_pkg::OUT_W-1:0] out_tdata
);
  import sshpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing
  sshpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table, update and result register
  sshpt_dp #(
    .NUM_CONNS (NUM_CONNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
